// ----- src/mcala_pkg.sv -----
package mcala_pkg;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    typedef struct packed {
        logic [3:0] channel;
        logic [7:0] data_byte;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] line_channel;
        logic [7:0] line_byte;
        logic       line_empty;
        logic       last;
    } ln_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

endpackage

// ----- src/multichannel_ascii_line_assembler.sv -----
// Multichannel line assembler.
// rx channel: one received byte per transfer, tagged with its source channel.
// A channel at or above CHANNELS is folded onto channel 0.
// ln channel: completed lines, one byte per transfer, in order, with last
// set on the final byte; an empty line gives a single transfer with
// line_empty and last set and a zero byte.
// An ordinary byte is taken and rx_ready stays high.
// A CR or LF that completes a line of N bytes holds rx_ready low while
// the line store is read out, one byte a cycle unless ln_ready stalls;
// each byte passes the registered store read and then the output
// register. An empty line holds rx_ready low until its marker is loaded
// into the output register. Lines of LINE_MAX bytes or more are dropped.
// A stall on ln_ready holds the output register and pauses the read-out;
// nothing is lost. Reset clears every fill index, sets every channel to
// accepting and leaves the line store contents as they are (no clearing
// pass needed, only written entries are ever read).
module multichannel_ascii_line_assembler #(
    parameter int LINE_MAX = 64,
    parameter int CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  mcala_pkg::rx_item_t rx_item,
    output logic                ln_valid,
    input  logic                ln_ready,
    output mcala_pkg::ln_item_t ln_item
);
    import mcala_pkg::*;

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW    = $clog2(LINE_MAX + 1);
    localparam int DEPTH = CHANNELS * LINE_MAX;
    localparam int AW    = $clog2(DEPTH);

    // Line store
    logic [7:0] line_mem [DEPTH];
    logic [7:0] rdata_reg;

    // Per-channel control state
    logic [FW-1:0] fill_reg [CHANNELS];
    logic          acc_reg  [CHANNELS];

    state_t        state_reg, state_next;
    logic [3:0]    drain_ch_reg, drain_ch_next;
    logic [FW-1:0] len_reg, len_next;
    logic [FW-1:0] issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          pend_empty_reg, pend_empty_next;
    logic          ln_valid_reg, ln_valid_next;
    ln_item_t      ln_item_reg, ln_item_next;

    logic [3:0]    rx_ch;
    logic [CW-1:0] rx_idx;
    logic [FW-1:0] fill_cur;
    logic          acc_cur;
    logic          overflow;
    logic [FW-1:0] idx;
    logic          acc_eff;
    logic          is_eol;
    logic          rx_fire;

    logic          upd_en;
    logic [FW-1:0] upd_fill;
    logic          upd_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          load_out;

    assign rx_ready = (state_reg == ST_IDLE);
    assign rx_fire  = rx_valid && rx_ready;
    assign ln_valid = ln_valid_reg;
    assign ln_item  = ln_item_reg;

    // Fold out-of-range channels onto channel 0
    assign rx_ch  = (32'(rx_item.channel) >= CHANNELS) ? 4'd0 : rx_item.channel;
    assign rx_idx = rx_ch[CW-1:0];

    assign fill_cur = fill_reg[rx_idx];
    assign acc_cur  = acc_reg[rx_idx];
    assign overflow = (fill_cur >= FW'(LINE_MAX));
    assign idx      = overflow ? '0 : fill_cur;
    assign acc_eff  = overflow ? 1'b0 : acc_cur;
    assign is_eol   = (rx_item.data_byte == CHAR_CR) || (rx_item.data_byte == CHAR_LF);

    assign wr_addr  = AW'(rx_idx) * AW'(LINE_MAX) + AW'(idx);
    assign rd_addr  = AW'(drain_ch_reg[CW-1:0]) * AW'(LINE_MAX) + AW'(issue_reg);
    assign load_out = pend_reg && (!ln_valid_reg || ln_ready);

    always_comb
    begin
        state_next      = state_reg;
        drain_ch_next   = drain_ch_reg;
        len_next        = len_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        pend_empty_next = pend_empty_reg;
        ln_valid_next   = ln_valid_reg;
        ln_item_next    = ln_item_reg;
        upd_en          = 1'b0;
        upd_fill        = fill_cur;
        upd_acc         = acc_cur;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        // Output register: drop a taken transfer, load the pending byte
        if (ln_valid_reg && ln_ready)
        begin
            ln_valid_next = 1'b0;
        end
        if (load_out)
        begin
            ln_valid_next           = 1'b1;
            ln_item_next.line_channel = drain_ch_reg[1:0];
            ln_item_next.line_byte  = pend_empty_reg ? 8'd0 : rdata_reg;
            ln_item_next.line_empty = pend_empty_reg;
            ln_item_next.last       = pend_last_reg;
            pend_next               = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire)
                begin
                    upd_en = 1'b1;
                    if (is_eol)
                    begin
                        upd_fill      = '0;
                        upd_acc       = 1'b1;
                        drain_ch_next = rx_ch;
                        issue_next    = '0;
                        len_next      = idx;
                        if (acc_eff)
                        begin
                            state_next = ST_DRAIN;
                            if (idx == '0)
                            begin
                                pend_next       = 1'b1;
                                pend_empty_next = 1'b1;
                                pend_last_next  = 1'b1;
                            end
                        end
                    end
                    else if (acc_eff)
                    begin
                        wr_en    = 1'b1;
                        upd_fill = idx + 1'b1;
                        upd_acc  = 1'b1;
                    end
                    else
                    begin
                        upd_fill = idx;
                        upd_acc  = acc_eff;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Issue the next read when the pending slot is free or frees this cycle
                if ((issue_reg != len_reg) && (!pend_reg || load_out))
                begin
                    rd_en           = 1'b1;
                    issue_next      = issue_reg + 1'b1;
                    pend_next       = 1'b1;
                    pend_empty_next = 1'b0;
                    pend_last_next  = ((issue_reg + 1'b1) == len_reg);
                end
                if ((issue_next == len_reg) && !pend_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= rx_item.data_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i] <= '0;
                acc_reg[i]  <= 1'b1;
            end
        end
        else if (upd_en)
        begin
            fill_reg[rx_idx] <= upd_fill;
            acc_reg[rx_idx]  <= upd_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            len_reg      <= '0;
            pend_reg     <= 1'b0;
            ln_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            len_reg      <= len_next;
            pend_reg     <= pend_next;
            ln_valid_reg <= ln_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_ch_reg   <= drain_ch_next;
        pend_last_reg  <= pend_last_next;
        pend_empty_reg <= pend_empty_next;
        ln_item_reg    <= ln_item_next;
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("pending byte left behind after read-out");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg <= len_reg)
        else $error("read-out ran past the line length");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ln_valid && ln_item.line_empty) |-> (ln_item.last && (ln_item.line_byte == 8'd0)))
        else $error("empty-line marker malformed");

    a_drain_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && is_eol && acc_eff) |=> !rx_ready)
        else $error("input taken while a line is read out");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcala_pkg::*;

    localparam int LINE_MAX   = 64;
    localparam int CHANNELS   = 4;
    localparam int STALL_LIMIT = 4000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     rx_valid = 1'b0;
    logic     rx_ready;
    rx_item_t rx_item = '0;
    logic     ln_valid;
    logic     ln_ready = 1'b0;
    ln_item_t ln_item;

    // Predictor state
    logic [7:0] line_buf [CHANNELS][LINE_MAX];
    logic [6:0] fill_cnt [CHANNELS];
    logic       taking   [CHANNELS];
    ln_item_t   pending_lines[$];

    int errors = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int lines_seen = 0;
    int empty_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ln_hold_left = 0;
    int quiet_cycles = 0;

    multichannel_ascii_line_assembler #(
        .LINE_MAX(LINE_MAX),
        .CHANNELS(CHANNELS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .rx_item (rx_item),
        .ln_valid(ln_valid),
        .ln_ready(ln_ready),
        .ln_item (ln_item)
    );

    always #1 clk = ~clk;

    // Work out the line transfers that one accepted byte releases
    function automatic void predict_line(input rx_item_t it);
        int       ch;
        int       i;
        ln_item_t r;
        ch = it.channel;
        if (ch >= CHANNELS)
            ch = 0;
        if (fill_cnt[ch] >= LINE_MAX)
        begin
            taking[ch]   = 1'b0;
            fill_cnt[ch] = '0;
        end
        if (it.data_byte == CHAR_CR || it.data_byte == CHAR_LF)
        begin
            if (taking[ch])
            begin
                if (fill_cnt[ch] == 0)
                begin
                    r.line_channel = 2'(ch);
                    r.line_byte    = 8'h00;
                    r.line_empty   = 1'b1;
                    r.last         = 1'b1;
                    pending_lines.push_back(r);
                end
                else
                begin
                    for (i = 0; i < fill_cnt[ch]; i++)
                    begin
                        r.line_channel = 2'(ch);
                        r.line_byte    = line_buf[ch][i];
                        r.line_empty   = 1'b0;
                        r.last         = (i + 1 == fill_cnt[ch]);
                        pending_lines.push_back(r);
                    end
                end
            end
            fill_cnt[ch] = '0;
            taking[ch]   = 1'b1;
        end
        else if (taking[ch] && fill_cnt[ch] < LINE_MAX)
        begin
            line_buf[ch][fill_cnt[ch]] = it.data_byte;
            fill_cnt[ch] = fill_cnt[ch] + 7'd1;
        end
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    task automatic send_byte(input logic [3:0] ch, input logic [7:0] b);
        rx_item_t it;
        it.channel   = ch;
        it.data_byte = b;
        if ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_item  <= it;
        do
            @(posedge clk);
        while (!rx_ready);
        predict_line(it);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [3:0] ch, input int n);
        repeat (n) send_byte(ch, text_char());
    endtask

    // Hold the sender back until every predicted transfer has come out
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lines.size() != 0);
    endtask

    task automatic test_short_lines();
        send_byte(4'd0, CHAR_CR);
        send_byte(4'd1, CHAR_LF);
        send_byte(4'd2, 8'h41);
        send_byte(4'd2, 8'h00);
        send_byte(4'd2, 8'hFF);
        send_byte(4'd2, CHAR_CR);
        // out-of-range channels fold onto channel 0
        send_byte(4'd15, 8'h78);
        send_byte(4'd15, CHAR_LF);
        send_byte(4'd4, CHAR_CR);
        send_byte(4'd3, 8'h61);
        send_byte(4'd1, 8'h62);
        send_byte(4'd3, 8'h63);
        send_byte(4'd1, CHAR_LF);
        send_byte(4'd3, CHAR_CR);
        send_byte(4'd2, CHAR_CR);
        send_byte(4'd2, CHAR_LF);
        send_byte(4'd10, 8'h55);
        send_byte(4'd5, 8'hAA);
        send_byte(4'd0, CHAR_CR);
        wait_drained();
    endtask

    task automatic test_line_length_limits();
        // longest line that still comes out
        send_text(4'd1, LINE_MAX - 1);
        send_byte(4'd1, CHAR_CR);
        // full line, end of line finds it full and drops it
        send_text(4'd2, LINE_MAX);
        send_byte(4'd2, CHAR_LF);
        send_byte(4'd2, CHAR_LF);
        // overflow byte stops accepting; further bytes are ignored
        send_text(4'd3, LINE_MAX + 1);
        send_text(4'd3, 3);
        send_byte(4'd3, CHAR_CR);
        send_byte(4'd3, 8'h7A);
        send_byte(4'd3, CHAR_CR);
        wait_drained();
    endtask

    task automatic test_output_stall();
        int saved_send;
        saved_send = send_idle_pct;
        send_idle_pct = 0;
        ln_hold_left = 300;
        send_text(4'd0, 20);
        send_byte(4'd0, CHAR_CR);
        send_text(4'd1, 20);
        send_byte(4'd1, CHAR_LF);
        send_text(4'd2, 12);
        send_byte(4'd2, CHAR_CR);
        send_byte(4'd3, CHAR_CR);
        wait_drained();
        send_idle_pct = saved_send;
    endtask

    task automatic test_mixed_traffic(input int n, input int s_pct, input int r_pct);
        int         start;
        int         len;
        logic [3:0] ch;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                ch  = 4'($urandom_range(15));
                len = ($urandom_range(9) == 0) ? $urandom_range(58, 68)
                                               : $urandom_range(0, 12);
                send_text(ch, len);
                send_byte(ch, $urandom_range(1) ? CHAR_CR : CHAR_LF);
            end
            else
                send_byte(4'($urandom_range(15)), 8'($urandom_range(255)));
        end
        wait_drained();
    endtask

    // Receiver: random back-pressure, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (ln_hold_left > 0)
        begin
            ln_ready <= 1'b0;
            ln_hold_left--;
        end
        else
            ln_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        ln_item_t want;
        if (rst_n && ln_valid && ln_ready)
        begin
            results_seen++;
            if (pending_lines.size() == 0)
            begin
                $error("unexpected line transfer: ch %0d byte %02h empty %0b last %0b",
                       ln_item.line_channel, ln_item.line_byte,
                       ln_item.line_empty, ln_item.last);
                errors++;
            end
            else
            begin
                want = pending_lines.pop_front();
                if (ln_item.line_channel !== want.line_channel)
                begin
                    $error("line_channel: expected %0d, got %0d",
                           want.line_channel, ln_item.line_channel);
                    errors++;
                end
                if (ln_item.line_byte !== want.line_byte)
                begin
                    $error("line_byte: expected %02h, got %02h",
                           want.line_byte, ln_item.line_byte);
                    errors++;
                end
                if (ln_item.line_empty !== want.line_empty)
                begin
                    $error("line_empty: expected %0b, got %0b",
                           want.line_empty, ln_item.line_empty);
                    errors++;
                end
                if (ln_item.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, ln_item.last);
                    errors++;
                end
                if (want.last)
                    lines_seen++;
                if (want.line_empty)
                    empty_seen++;
            end
        end
    end

    // Abort when neither side has moved a transfer for too long
    always @(posedge clk)
    begin
        if ((rx_valid && rx_ready) || (ln_valid && ln_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            fill_cnt[c] = '0;
            taking[c]   = 1'b1;
        end
        send_idle_pct = 38;
        recv_idle_pct = 47;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_lines();
        test_line_length_limits();
        test_output_stall();
        test_mixed_traffic(25, 38, 47);
        test_mixed_traffic(25, 47, 38);
        test_mixed_traffic(25, 0, 0);

        wait_drained();
        // allow for a late stray transfer
        repeat (80) @(posedge clk);

        $display("Sent %0d bytes; checked %0d line transfers over %0d lines (%0d empty).",
                 bytes_sent, results_seen, lines_seen, empty_seen);
        $display("Covered folded channels, full and overflowed lines and a long output stall.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- multichannel_ascii_line_assembler.f -----
src/mcala_pkg.sv
src/multichannel_ascii_line_assembler.sv
dv/tb_top.sv
